// ===== sv/msdi_pkg.sv =====
// ----------------------------------------------------------------------------
// msdi_pkg
// Shared constants, types and helpers of the masked slice doubling
// interpolator: geometry limits, field widths, queue entry and config types.
// ----------------------------------------------------------------------------
package msdi_pkg;

   localparam int MAX_SLICES = 64;
   localparam int MAX_ROWS   = 128;
   localparam int MAX_COLS   = 128;

   localparam int SAMPLE_W   = 16;
   localparam int VALUE_W    = SAMPLE_W + 1;
   localparam int OUT_IDX_W  = 7;

   localparam int SLICE_W    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   localparam int PLANE_AW   = ROW_W + COL_W;
   localparam int MASK_AW    = SLICE_W + PLANE_AW;
   localparam int PLANE_DEPTH = 2 ** PLANE_AW;
   localparam int MASK_DEPTH  = 2 ** MASK_AW;

   // compare width: holds every register value and every limit plus one
   localparam int CMP_W      = 11;

   localparam int CUTOFF_W   = 16;
   localparam int NSLICE_W   = 7;
   localparam int NROW_W     = 8;
   localparam int NCOL_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic signed [CUTOFF_W-1:0] CUTOFF_RESET = '0;
   localparam logic [NSLICE_W-1:0]        SLICES_RESET = NSLICE_W'(64);
   localparam logic [NROW_W-1:0]          ROWS_RESET   = NROW_W'(128);
   localparam logic [NCOL_W-1:0]          COLS_RESET   = NCOL_W'(128);

   localparam int REQ_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_FLD_W  = VALUE_W + 3 * OUT_IDX_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FLD_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUTOFF = 2'd0,
      CSR_SLICES = 2'd1,
      CSR_ROWS   = 2'd2,
      CSR_COLS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CUTOFF_W-1:0] cutoff_level;
      logic [NSLICE_W-1:0]        slices_in_use;
      logic [NROW_W-1:0]          rows_in_use;
      logic [NCOL_W-1:0]          cols_in_use;
   } cfg_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] copy_value;
      logic signed [VALUE_W-1:0] interp_value;
      logic [SLICE_W-1:0]        slice;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic                      has_interp;
      logic                      last_voxel;
   } entry_type;

   typedef enum logic {
      BACK_HEAD = 1'b0,
      BACK_COPY = 1'b1
   } back_state_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic logic [CMP_W-1:0] clamp_dim(input logic [CMP_W-1:0] v,
                                                   input logic [CMP_W-1:0] maxv);
      logic [CMP_W-1:0] res;
      if (v == '0) begin
         res = CMP_W'(1);
      end else if (v > maxv) begin
         res = maxv;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

// ===== sv/msdi_queue.sv =====
// ----------------------------------------------------------------------------
// msdi_queue
// Short first-in first-out queue of classified voxels between the front
// and the back part.
// ----------------------------------------------------------------------------
module msdi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  msdi_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output msdi_pkg::entry_type pop_data
);
   import msdi_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/msdi_front.sv =====
// ----------------------------------------------------------------------------
// msdi_front
// Accepts samples, tracks the raster position, keeps the first-volume mask
// and the previous-slice store, and builds copy and mean values per voxel.
// ----------------------------------------------------------------------------
module msdi_front (
   input  logic                             clock,
   input  logic                             reset,
   input  msdi_pkg::cfg_type                cfg,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [msdi_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             push_valid,
   input  logic                             push_ready,
   output msdi_pkg::entry_type              push_data
);
   import msdi_pkg::*;

   // position counters
   logic [SLICE_W-1:0] slice_count_ff, slice_count_in;
   logic [ROW_W-1:0]   row_count_ff, row_count_in;
   logic [COL_W-1:0]   col_count_ff, col_count_in;
   logic               first_volume_ff, first_volume_in;

   logic [CMP_W-1:0]   ns, nr, nc;
   logic               end_c, end_r, end_s;
   logic               accept, push;
   logic [MASK_AW-1:0] a3;
   logic [PLANE_AW-1:0] a2;
   logic signed [SAMPLE_W-1:0] sample;
   logic               pass;

   // stores
   logic                       mask_mem [MASK_DEPTH];
   logic signed [SAMPLE_W-1:0] prev_mem [PLANE_DEPTH];

   // second stage
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [SAMPLE_W-1:0] s2_sample_ff;
   logic                       s2_pass_ff;
   logic                       s2_first_ff;
   logic [SLICE_W-1:0]         s2_slice_ff;
   logic [ROW_W-1:0]           s2_row_ff;
   logic [COL_W-1:0]           s2_col_ff;
   logic                       s2_last_ff;
   logic                       mask_rd_ff;
   logic signed [SAMPLE_W-1:0] prev_rd_ff;
   logic                       fwd_hit_ff;
   logic signed [SAMPLE_W-1:0] fwd_data_ff;

   logic [PLANE_AW-1:0]        s2_a2;
   logic                       s2_keep;
   logic signed [SAMPLE_W-1:0] s2_m;
   logic signed [SAMPLE_W-1:0] s2_prev;

   assign ns = clamp_dim(CMP_W'(cfg.slices_in_use), CMP_W'(MAX_SLICES));
   assign nr = clamp_dim(CMP_W'(cfg.rows_in_use), CMP_W'(MAX_ROWS));
   assign nc = clamp_dim(CMP_W'(cfg.cols_in_use), CMP_W'(MAX_COLS));

   assign end_c = (CMP_W'(col_count_ff) + CMP_W'(1)) >= nc;
   assign end_r = (CMP_W'(row_count_ff) + CMP_W'(1)) >= nr;
   assign end_s = (CMP_W'(slice_count_ff) + CMP_W'(1)) >= ns;

   assign push       = s2_valid_ff && push_ready;
   assign req_tready = !s2_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   assign a2     = {row_count_ff, col_count_ff};
   assign a3     = {slice_count_ff, a2};
   assign sample = signed'(req_tdata[SAMPLE_W-1:0]);
   assign pass   = sample > cfg.cutoff_level;

   always_comb begin
      col_count_in    = col_count_ff;
      row_count_in    = row_count_ff;
      slice_count_in  = slice_count_ff;
      first_volume_in = first_volume_ff;
      if (accept) begin
         if (end_c) begin
            col_count_in = '0;
            if (end_r) begin
               row_count_in = '0;
               if (end_s) begin
                  slice_count_in  = '0;
                  first_volume_in = 1'b0;
               end else begin
                  slice_count_in = slice_count_ff + SLICE_W'(1);
               end
            end else begin
               row_count_in = row_count_ff + ROW_W'(1);
            end
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (push) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff    <= '0;
         row_count_ff    <= '0;
         slice_count_ff  <= '0;
         first_volume_ff <= 1'b1;
         s2_valid_ff     <= 1'b0;
      end else begin
         col_count_ff    <= col_count_in;
         row_count_ff    <= row_count_in;
         slice_count_ff  <= slice_count_in;
         first_volume_ff <= first_volume_in;
         s2_valid_ff     <= s2_valid_in;
      end
   end

   // mask store: written through the first volume, read every voxel
   always_ff @(posedge clock) begin
      if (accept) begin
         if (first_volume_ff) begin
            mask_mem[a3] <= pass;
         end
         mask_rd_ff <= mask_mem[a3];
      end
   end

   // previous-slice store: read on accept, written as the voxel leaves
   always_ff @(posedge clock) begin
      if (push) begin
         prev_mem[s2_a2] <= s2_m;
      end
      if (accept) begin
         prev_rd_ff <= prev_mem[a2];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_sample_ff <= sample;
         s2_pass_ff   <= pass;
         s2_first_ff  <= first_volume_ff;
         s2_slice_ff  <= slice_count_ff;
         s2_row_ff    <= row_count_ff;
         s2_col_ff    <= col_count_ff;
         s2_last_ff   <= end_c && end_r && end_s;
         // forward a write that lands on the same edge as this read
         fwd_hit_ff   <= push && (s2_a2 == a2);
         fwd_data_ff  <= s2_m;
      end
   end

   assign s2_a2   = {s2_row_ff, s2_col_ff};
   assign s2_keep = s2_first_ff ? s2_pass_ff : mask_rd_ff;
   assign s2_m    = s2_keep ? s2_sample_ff : '0;
   assign s2_prev = fwd_hit_ff ? fwd_data_ff : prev_rd_ff;

   always_comb begin
      push_data.copy_value   = VALUE_W'(s2_m) <<< 1;
      push_data.interp_value = VALUE_W'(s2_prev) + VALUE_W'(s2_m);
      push_data.slice        = s2_slice_ff;
      push_data.row          = s2_row_ff;
      push_data.col          = s2_col_ff;
      push_data.has_interp   = (s2_slice_ff != '0);
      push_data.last_voxel   = s2_last_ff;
   end

   assign push_valid = s2_valid_ff;

endmodule

// ===== sv/msdi_back.sv =====
// ----------------------------------------------------------------------------
// msdi_back
// Turns each queued voxel into its results: the mean for the odd output
// slice when there is one, then the copy for the even slice.
// ----------------------------------------------------------------------------
module msdi_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  msdi_pkg::entry_type              pop_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [msdi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);
   import msdi_pkg::*;

   back_state_type state_ff, state_in;

   logic                      out_free;
   logic                      load;
   logic                      emit_interp;
   logic signed [VALUE_W-1:0] value;
   logic [OUT_IDX_W-1:0]      out_slice;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;
   logic                      rsp_tlast_ff;
   logic                      rsp_tuser_ff;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign load     = out_free && pop_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_HEAD: begin
            if (load && pop_data.has_interp) begin
               state_in = BACK_COPY;
            end
         end
         BACK_COPY: begin
            if (load) begin
               state_in = BACK_HEAD;
            end
         end
         default: state_in = BACK_HEAD;
      endcase
   end

   always_comb begin
      emit_interp = 1'b0;
      case (state_ff)
         BACK_HEAD: emit_interp = pop_data.has_interp;
         BACK_COPY: emit_interp = 1'b0;
         default:   emit_interp = 1'b0;
      endcase
      pop_ready = out_free && !emit_interp;
   end

   always_comb begin
      if (emit_interp) begin
         value     = pop_data.interp_value;
         out_slice = OUT_IDX_W'({pop_data.slice, 1'b0}) - OUT_IDX_W'(1);
      end else begin
         value     = pop_data.copy_value;
         out_slice = OUT_IDX_W'({pop_data.slice, 1'b0});
      end
      rsp_tvalid_in = load ? 1'b1 : (out_free ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_HEAD;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata_ff <= {RSP_PAD_W'(0), OUT_IDX_W'(pop_data.col), OUT_IDX_W'(pop_data.row),
                          out_slice, value};
         rsp_tlast_ff <= !emit_interp;
         rsp_tuser_ff <= !emit_interp && pop_data.last_voxel;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== sv/masked_slice_doubling_interpolator.sv =====
// An accepted sample passes the front's second stage, the queue and the result register
// before its first result shows on rsp. Throughput: one sample per cycle on input slice 0;
// later slices give two results per sample, and the result port, which moves one voxel per
// cycle while rsp_tready is high, sets the rate. Reset clears the position counters, the
// first-volume flag and the queue, and restores the registers to their defaults; the mask
// and slice stores keep their contents and are valid once written.
// ----------------------------------------------------------------------------
// masked_slice_doubling_interpolator
// Doubles the slice count of a volume stream by linear interpolation,
// zeroing voxels that fail the first-volume cutoff.
// ----------------------------------------------------------------------------
module masked_slice_doubling_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [msdi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msdi_pkg::CSR_DATA_W-1:0]  csr_data,
   // input samples
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [msdi_pkg::REQ_DATA_W-1:0]  req_tdata,   // [15:0] sample
   // output voxels
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [msdi_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [16:0] value, [23:17] out_slice,
                                                         // [30:24] out_row, [37:31] out_col
   output logic                             rsp_tlast,   // run_last
   output logic                             rsp_tuser    // [0] volume_end
);
   import msdi_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      csr_write;
   logic      push_valid, push_ready;
   entry_type push_data;
   logic      pop_valid, pop_ready;
   entry_type pop_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CUTOFF: cfg_in.cutoff_level  = signed'(csr_data[CUTOFF_W-1:0]);
            CSR_SLICES: cfg_in.slices_in_use = csr_data[NSLICE_W-1:0];
            CSR_ROWS:   cfg_in.rows_in_use   = csr_data[NROW_W-1:0];
            CSR_COLS:   cfg_in.cols_in_use   = csr_data[NCOL_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cutoff_level  <= CUTOFF_RESET;
         cfg_ff.slices_in_use <= SLICES_RESET;
         cfg_ff.rows_in_use   <= ROWS_RESET;
         cfg_ff.cols_in_use   <= COLS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msdi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   msdi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   msdi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked slice doubling interpolator. Builds the
// mask in one first volume with a 64-slice, 2x2 geometry, then streams
// directed and random volumes of varying geometry inside that footprint,
// changing registers between phases, also in mid-volume. An internal model
// of the interpolator predicts every output voxel and the scoreboard
// compares each one with what comes out, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msdi_pkg::*;

   localparam int SLICE_LSB = VALUE_W;
   localparam int ROW_LSB   = SLICE_LSB + OUT_IDX_W;
   localparam int COL_LSB   = ROW_LSB + OUT_IDX_W;

   typedef struct {
      bit signed [VALUE_W-1:0] value;
      bit [OUT_IDX_W-1:0]      out_slice;
      bit [OUT_IDX_W-1:0]      out_row;
      bit [OUT_IDX_W-1:0]      out_col;
      bit                      run_last;
      bit                      volume_end;
   } voxel_type;

   class voxel_scoreboard;
      bit                       mask_bits [MASK_DEPTH];
      bit signed [SAMPLE_W-1:0] prev_plane [PLANE_DEPTH];
      int unsigned              col_cnt, row_cnt, slice_cnt;
      bit                       first_vol;
      bit signed [CUTOFF_W-1:0] cutoff;
      bit [NSLICE_W-1:0]        slices;
      bit [NROW_W-1:0]          rows;
      bit [NCOL_W-1:0]          cols;
      voxel_type                expected_voxels [$];
      int                       failures;

      function new();
         first_vol = 1'b1;
         cutoff    = CUTOFF_RESET;
         slices    = SLICES_RESET;
         rows      = ROWS_RESET;
         cols      = COLS_RESET;
         col_cnt   = 0;
         row_cnt   = 0;
         slice_cnt = 0;
         failures  = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CUTOFF: cutoff = data;
            CSR_SLICES: slices = data[NSLICE_W-1:0];
            CSR_ROWS:   rows   = data[NROW_W-1:0];
            CSR_COLS:   cols   = data[NCOL_W-1:0];
            default:    ;
         endcase
      endfunction

      // zero behaves as one, oversize behaves as the maximum
      function int unsigned dim_limit(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         return (v > maxv) ? maxv : v;
      endfunction

      function int pending();
         return expected_voxels.size();
      endfunction

      function void note_sample(bit [SAMPLE_W-1:0] raw);
         int unsigned              ns, nr, nc, a2, a3;
         bit signed [SAMPLE_W-1:0] x, m;
         bit                       end_c, end_r, end_s;
         voxel_type                v;
         ns = dim_limit(slices, MAX_SLICES);
         nr = dim_limit(rows, MAX_ROWS);
         nc = dim_limit(cols, MAX_COLS);
         a2 = row_cnt * MAX_COLS + col_cnt;
         a3 = slice_cnt * MAX_ROWS * MAX_COLS + a2;
         x  = raw;
         end_c = col_cnt + 1 >= nc;
         end_r = row_cnt + 1 >= nr;
         end_s = slice_cnt + 1 >= ns;
         if (first_vol) mask_bits[a3] = (x > cutoff);
         m = mask_bits[a3] ? x : '0;
         v.out_row = OUT_IDX_W'(row_cnt);
         v.out_col = OUT_IDX_W'(col_cnt);
         if (slice_cnt > 0) begin
            v.value      = prev_plane[a2] + m;
            v.out_slice  = OUT_IDX_W'(2 * slice_cnt - 1);
            v.run_last   = 1'b0;
            v.volume_end = 1'b0;
            expected_voxels.push_back(v);
         end
         v.value      = m + m;
         v.out_slice  = OUT_IDX_W'(2 * slice_cnt);
         v.run_last   = 1'b1;
         v.volume_end = end_c && end_r && end_s;
         expected_voxels.push_back(v);
         prev_plane[a2] = m;
         // advance raster position; counters past a shrunk limit wrap as well
         if (!end_c) begin
            col_cnt++;
         end else begin
            col_cnt = 0;
            if (!end_r) begin
               row_cnt++;
            end else begin
               row_cnt = 0;
               if (!end_s) begin
                  slice_cnt++;
               end else begin
                  slice_cnt = 0;
                  first_vol = 1'b0;
               end
            end
         end
      endfunction

      function void check_voxel(bit [RSP_DATA_W-1:0] data, bit last, bit vend);
         voxel_type               e;
         bit signed [VALUE_W-1:0] got_value;
         bit [OUT_IDX_W-1:0]      got_slice, got_row, got_col;
         if (expected_voxels.size() == 0) begin
            $error("unexpected voxel transaction: tdata %h", data);
            failures++;
            return;
         end
         e         = expected_voxels.pop_front();
         got_value = data[VALUE_W-1:0];
         got_slice = data[SLICE_LSB +: OUT_IDX_W];
         got_row   = data[ROW_LSB +: OUT_IDX_W];
         got_col   = data[COL_LSB +: OUT_IDX_W];
         if (got_value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, got_value);
            failures++;
         end
         if (got_slice !== e.out_slice) begin
            $error("out_slice: expected %0d, got %0d", e.out_slice, got_slice);
            failures++;
         end
         if (got_row !== e.out_row) begin
            $error("out_row: expected %0d, got %0d", e.out_row, got_row);
            failures++;
         end
         if (got_col !== e.out_col) begin
            $error("out_col: expected %0d, got %0d", e.out_col, got_col);
            failures++;
         end
         if (last !== e.run_last) begin
            $error("run_last: expected %0d, got %0d", e.run_last, last);
            failures++;
         end
         if (vend !== e.volume_end) begin
            $error("volume_end: expected %0d, got %0d", e.volume_end, vend);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [15:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [16:0] value, [23:17] out_slice,
                                           // [30:24] out_row, [37:31] out_col
   logic                  rsp_tlast;       // run_last
   logic                  rsp_tuser;       // [0] volume_end

   voxel_scoreboard sb = new();
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int rsp_stall = 0;

   masked_slice_doubling_interpolator i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int pick_gap(inout bit calm);
      if ($urandom_range(0, 49) == 0) calm = !calm;
      if (calm) return 0;
      case ($urandom_range(0, 9))
         6, 7, 8: return $urandom_range(1, 3);
         9:       return $urandom_range(4, 20);
         default: return 0;
      endcase
   endfunction

   function automatic bit [SAMPLE_W-1:0] pick_sample(int cut);
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2, 3:    return SAMPLE_W'(cut + int'($urandom_range(0, 4)) - 2);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic write_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic send_sample(bit [SAMPLE_W-1:0] sample);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(sample);
      do @(posedge clock); while (!req_tready);
      sb.note_sample(sample);
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_samples(int n, int cut);
      repeat (n) send_sample(pick_sample(cut));
      req_tvalid <= 1'b0;
   endtask

   // hold until every voxel is out, then let the pipeline settle
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_voxel(rsp_tdata, rsp_tlast, rsp_tuser);
      if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_stall = pick_gap(rsp_calm);
         rsp_tready <= (rsp_stall == 0);
      end
   end

   initial begin
      int                  cut;
      int                  n;
      int                  later_count;
      bit [SAMPLE_W-1:0]   first_vals [8];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // register extremes, then the mask-building geometry: 64 x 2 x 2
      cut = int'($urandom_range(0, 16000)) - 8000;
      write_reg(CSR_CUTOFF, 16'h7fff);
      write_reg(CSR_CUTOFF, 16'h8000);
      write_reg(CSR_SLICES, 16'd0);
      write_reg(CSR_ROWS, 16'd255);
      write_reg(CSR_COLS, 16'd128);
      write_reg(CSR_SLICES, 16'd64);
      write_reg(CSR_ROWS, 16'd128);
      write_reg(CSR_COLS, 16'd0);
      write_reg(CSR_CUTOFF, CSR_DATA_W'(cut));
      write_reg(CSR_SLICES, 16'd127);
      write_reg(CSR_ROWS, 16'd2);
      write_reg(CSR_COLS, 16'd2);
      csr_valid <= 1'b0;

      // slice 0 then slice 1: full-scale, masked-out and cutoff-edge voxels
      first_vals = '{16'h7fff, 16'h8000, SAMPLE_W'(cut + 1), SAMPLE_W'(cut),
                     16'h7fff, 16'h7fff, 16'h8000, 16'h0000};
      foreach (first_vals[i]) send_sample(first_vals[i]);
      send_samples(MAX_SLICES * 4 - 8, cut);
      wait_drained();

      // single-slice, single-voxel volumes from zero geometry
      write_reg(CSR_SLICES, 16'd0);
      write_reg(CSR_ROWS, 16'd0);
      write_reg(CSR_COLS, 16'd0);
      csr_valid <= 1'b0;
      send_samples(3, cut);
      wait_drained();

      write_reg(CSR_SLICES, 16'd1);
      write_reg(CSR_ROWS, 16'd2);
      write_reg(CSR_COLS, 16'd2);
      csr_valid <= 1'b0;
      send_samples(4, cut);
      wait_drained();

      // shrink columns mid-slice so the column counter sits past its limit
      write_reg(CSR_SLICES, 16'd3);
      csr_valid <= 1'b0;
      send_samples(3, cut);
      wait_drained();
      write_reg(CSR_COLS, 16'd1);
      csr_valid <= 1'b0;
      send_samples(4, cut);

      later_count = 0;
      while (later_count < 170) begin
         wait_drained();
         if ($urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 1) != 0)
               write_reg(CSR_CUTOFF, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 1) != 0) begin
               case ($urandom_range(0, 9))
                  0:       n = 0;
                  1:       n = 1;
                  2:       n = MAX_SLICES;
                  3:       n = $urandom_range(MAX_SLICES + 1, 127);
                  default: n = $urandom_range(2, 8);
               endcase
               write_reg(CSR_SLICES, {9'($urandom), 7'(n)});
            end
            if ($urandom_range(0, 1) != 0)
               write_reg(CSR_ROWS, {8'($urandom), 8'($urandom_range(0, 2))});
            if ($urandom_range(0, 1) != 0)
               write_reg(CSR_COLS, {8'($urandom), 8'($urandom_range(0, 2))});
            csr_valid <= 1'b0;
         end
         n = $urandom_range(1, 40);
         send_samples(n, cut);
         later_count += n;
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
